[rtl/lcdn_pkg.sv]
// shared types, codes and the nibble sequencing table for the character lcd interface
package lcdn_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] column;
        logic [1:0] row_sel;
        logic [7:0] char_code;
        logic       begins_run;
    } req_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] pause_before_us;
        logic [11:0] pause_after_us;
        logic        last;
    } nib_t;

    typedef enum logic [1:0] {
        CMD_INIT       = 2'd0,
        CMD_CLEAR      = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_WRITE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SETTLE    = 2'd0,
        CFG_LONG_WAIT = 2'd1,
        CFG_POWER_UP  = 2'd2,
        CFG_ROW_BASES = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  settle_us;
        logic [11:0] long_wait_us;
        logic [15:0] power_up_wait_us;
        logic [31:0] row_bases;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_CLEAR,
        JOB_WRITE
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       has_addr;
        logic [7:0] addr;
        logic [7:0] char_code;
    } job_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_SETTLE,
        WAIT_LONG
    } wait_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       first;
        wait_t      after;
        logic       last_byte;
    } step_t;

    localparam logic [7:0] LCD_FUNC_RESET = 8'h03;
    localparam logic [7:0] LCD_FOUR_BIT   = 8'h02;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;

    localparam logic [7:0]  RST_SETTLE_US    = 8'd40;
    localparam logic [11:0] RST_LONG_WAIT_US = 12'd1640;
    localparam logic [15:0] RST_POWER_UP_US  = 16'd15000;
    localparam logic [31:0] RST_ROW_BASES    = 32'hD494C080;

    localparam logic [2:0] WRITE_ADDR_IDX = 3'd0;
    localparam logic [2:0] WRITE_CHAR_IDX = 3'd1;
    localparam logic [2:0] INIT_LAST_IDX  = 3'd7;

    function automatic step_t step_lookup(job_kind_t kind, logic [2:0] idx,
                                          logic [7:0] addr, logic [7:0] ch);
        step_t s;
        s = '{rs: 1'b0, data: LCD_CLEAR, first: 1'b0, after: WAIT_LONG, last_byte: 1'b1};
        unique case (kind)
            JOB_INIT:
            begin
                s.last_byte = 1'b0;
                unique case (idx)
                    3'd0:
                    begin
                        s.data  = LCD_FUNC_RESET;
                        s.first = 1'b1;
                        s.after = WAIT_LONG;
                    end
                    3'd1, 3'd2:
                    begin
                        s.data  = LCD_FUNC_RESET;
                        s.after = WAIT_LONG;
                    end
                    3'd3:
                    begin
                        s.data  = LCD_FOUR_BIT;
                        s.after = WAIT_SETTLE;
                    end
                    3'd4:
                    begin
                        s.data  = LCD_FUNC_SET;
                        s.after = WAIT_NONE;
                    end
                    3'd5:
                    begin
                        s.data  = LCD_DISP_ON;
                        s.after = WAIT_NONE;
                    end
                    3'd6:
                    begin
                        s.data  = LCD_ENTRY_MODE;
                        s.after = WAIT_NONE;
                    end
                    default:
                    begin
                        s.data      = LCD_CLEAR;
                        s.after     = WAIT_LONG;
                        s.last_byte = 1'b1;
                    end
                endcase
            end
            JOB_CLEAR:
            begin
                s.data  = LCD_CLEAR;
                s.after = WAIT_LONG;
            end
            JOB_WRITE:
            begin
                s.after = WAIT_NONE;
                if (idx == WRITE_ADDR_IDX)
                begin
                    s.data      = addr;
                    s.last_byte = 1'b0;
                end
                else
                begin
                    s.rs   = 1'b1;
                    s.data = ch;
                end
            end
            default:
            begin
                s.data = LCD_CLEAR;
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/char_lcd_nibble_interface.sv]
// top level of the 4-bit character lcd interface: config registers, intake, queue, sequencer
// a request reaches nib through the job queue, the job register and the output register
// throughput: one nibble beat per cycle while nib_stall is low; init gives 16 beats, clear 2,
// write 2 or 4, set cursor none; the sequencer's nibble step sets the rate
// a request is taken every cycle while the job queue has room
// reset clears cursor, queue and output valid, and loads the default timing and row bases
module char_lcd_nibble_interface #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lcdn_pkg::req_t req,
    output logic           nib_valid,
    input  logic           nib_stall,
    output lcdn_pkg::nib_t nib,
    input  logic           cfg_write,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import lcdn_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic head_valid;
    job_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SETTLE:    cfg_next.settle_us        = cfg_data[7:0];
                CFG_LONG_WAIT: cfg_next.long_wait_us     = cfg_data[11:0];
                CFG_POWER_UP:  cfg_next.power_up_wait_us = cfg_data[15:0];
                CFG_ROW_BASES: cfg_next.row_bases        = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_us        <= RST_SETTLE_US;
            cfg_reg.long_wait_us     <= RST_LONG_WAIT_US;
            cfg_reg.power_up_wait_us <= RST_POWER_UP_US;
            cfg_reg.row_bases        <= RST_ROW_BASES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcdn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg       (cfg_reg),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    lcdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .nib_valid  (nib_valid),
        .nib_stall  (nib_stall),
        .nib        (nib)
    );

endmodule

[rtl/lcdn_front.sv]
// request intake: tracks the cursor, drops set cursor, and turns requests into jobs
module lcdn_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lcdn_pkg::req_t req,
    input  lcdn_pkg::cfg_t cfg,
    output logic           push,
    output lcdn_pkg::job_t push_job,
    input  logic           q_full
);
    import lcdn_pkg::*;

    logic [7:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic       accept;
    cmd_t       cmd;
    logic [7:0] base;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign cmd       = cmd_t'(req.command);

    always_comb
    begin
        unique case (row_reg)
            2'd0:    base = cfg.row_bases[7:0];
            2'd1:    base = cfg.row_bases[15:8];
            2'd2:    base = cfg.row_bases[23:16];
            default: base = cfg.row_bases[31:24];
        endcase
    end

    always_comb
    begin
        col_next           = col_reg;
        row_next           = row_reg;
        push               = 1'b0;
        push_job.kind      = JOB_WRITE;
        push_job.has_addr  = req.begins_run;
        push_job.addr      = base + col_reg;
        push_job.char_code = req.char_code;
        if (accept)
        begin
            unique case (cmd)
                CMD_INIT:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_INIT;
                    col_next      = '0;
                    row_next      = '0;
                end
                CMD_CLEAR:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_CLEAR;
                    col_next      = '0;
                    row_next      = '0;
                end
                CMD_SET_CURSOR:
                begin
                    col_next = {2'b00, req.column};
                    row_next = req.row_sel;
                end
                CMD_WRITE:
                begin
                    push     = 1'b1;
                    col_next = col_reg + 8'd1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/lcdn_queue.sv]
// short job queue between intake and nibble sequencer
module lcdn_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcdn_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lcdn_pkg::job_t head
);
    import lcdn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !head_valid))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

[rtl/lcdn_back.sv]
// nibble sequencer: expands each job into timed nibble beats behind an output register
module lcdn_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lcdn_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  lcdn_pkg::job_t head,
    output logic           pop,
    output logic           nib_valid,
    input  logic           nib_stall,
    output lcdn_pkg::nib_t nib
);
    import lcdn_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic        half_reg, half_next;
    job_t        job_reg;
    logic        out_valid_reg, out_valid_next;
    nib_t        out_reg, out_next;
    step_t       step;
    logic        advance;
    logic [16:0] first_sum;
    logic [15:0] first_wait;
    logic [11:0] after_wait;

    assign step       = step_lookup(job_reg.kind, idx_reg, job_reg.addr, job_reg.char_code);
    assign advance    = busy_reg && (!out_valid_reg || !nib_stall);
    assign pop        = head_valid && (!busy_reg || (advance && half_reg && step.last_byte));
    assign first_sum  = {1'b0, cfg.power_up_wait_us} + {9'b0, cfg.settle_us};
    assign first_wait = first_sum[16] ? 16'hFFFF : first_sum[15:0];

    always_comb
    begin
        unique case (step.after)
            WAIT_NONE:   after_wait = '0;
            WAIT_SETTLE: after_wait = {4'b0, cfg.settle_us};
            WAIT_LONG:   after_wait = cfg.long_wait_us;
            default:     after_wait = '0;
        endcase
    end

    // output beat for the current position
    always_comb
    begin
        out_next.reg_select = step.rs;
        if (!half_reg)
        begin
            out_next.nibble          = step.data[7:4];
            out_next.pause_before_us = step.first ? first_wait : {8'b0, cfg.settle_us};
            out_next.pause_after_us  = '0;
            out_next.last            = 1'b0;
        end
        else
        begin
            out_next.nibble          = step.data[3:0];
            out_next.pause_before_us = '0;
            out_next.pause_after_us  = after_wait;
            out_next.last            = step.last_byte;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!nib_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            if (!half_reg)
            begin
                half_next = 1'b1;
            end
            else if (step.last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                half_next = 1'b0;
                idx_next  = idx_reg + 3'd1;
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
            half_next = 1'b0;
            idx_next  = (head.kind == JOB_WRITE && !head.has_addr) ? WRITE_CHAR_IDX : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign nib_valid = out_valid_reg;
    assign nib       = out_reg;

    a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |-> (out_reg.pause_before_us == '0))
        else $error("last beat is not a low nibble");
    a_clear_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && job_reg.kind == JOB_CLEAR) |-> (idx_reg == '0))
        else $error("clear job past its only byte");
    a_write_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && job_reg.kind == JOB_WRITE) |-> (idx_reg <= WRITE_CHAR_IDX))
        else $error("write job past its character byte");
    a_init_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && job_reg.kind == JOB_INIT) |-> (idx_reg <= INIT_LAST_IDX))
        else $error("init job index out of range");

endmodule

[tb/testbench.sv]
// self-checking testbench for the 4-bit character lcd interface: request driver, nibble monitor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdn_pkg::*;

    localparam int PERIOD      = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_GAP  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        nib_valid;
    logic        nib_stall = 1'b0;
    nib_t        nib;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    req_t req_queue[$];
    nib_t nib_expect[$];
    logic req_done = 1'b0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_on = 1'b0;
    int hold_count = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int req_count = 0;
    int nib_count = 0;

    logic [7:0]  settle = RST_SETTLE_US;
    logic [11:0] long_wait = RST_LONG_WAIT_US;
    logic [15:0] power_up = RST_POWER_UP_US;
    logic [31:0] row_bases = RST_ROW_BASES;
    logic [7:0]  cur_col = '0;
    logic [1:0]  cur_row = '0;

    char_lcd_nibble_interface DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .nib_valid (nib_valid),
        .nib_stall (nib_stall),
        .nib       (nib),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic void queue_byte(logic rs, logic [7:0] data, logic [15:0] pause_pre,
                                       logic [11:0] after);
        nib_t n;
        n = '{reg_select: rs, nibble: data[7:4], pause_before_us: pause_pre,
              pause_after_us: 12'd0, last: 1'b0};
        nib_expect.push_back(n);
        n = '{reg_select: rs, nibble: data[3:0], pause_before_us: 16'd0,
              pause_after_us: after, last: 1'b0};
        nib_expect.push_back(n);
    endfunction

    function automatic void predict_nibbles(req_t r);
        int          start_size;
        logic [16:0] first_wait;
        logic [7:0]  addr;
        nib_t        tail;
        start_size = nib_expect.size();
        first_wait = {1'b0, power_up} + {9'd0, settle};
        case (cmd_t'(r.command))
            CMD_INIT:
            begin
                queue_byte(1'b0, LCD_FUNC_RESET, first_wait[16] ? 16'hFFFF : first_wait[15:0],
                           long_wait);
                queue_byte(1'b0, LCD_FUNC_RESET, {8'd0, settle}, long_wait);
                queue_byte(1'b0, LCD_FUNC_RESET, {8'd0, settle}, long_wait);
                queue_byte(1'b0, LCD_FOUR_BIT, {8'd0, settle}, {4'd0, settle});
                queue_byte(1'b0, LCD_FUNC_SET, {8'd0, settle}, 12'd0);
                queue_byte(1'b0, LCD_DISP_ON, {8'd0, settle}, 12'd0);
                queue_byte(1'b0, LCD_ENTRY_MODE, {8'd0, settle}, 12'd0);
                queue_byte(1'b0, LCD_CLEAR, {8'd0, settle}, long_wait);
                cur_col = '0;
                cur_row = '0;
            end
            CMD_CLEAR:
            begin
                queue_byte(1'b0, LCD_CLEAR, {8'd0, settle}, long_wait);
                cur_col = '0;
                cur_row = '0;
            end
            CMD_SET_CURSOR:
            begin
                cur_col = {2'b00, r.column};
                cur_row = r.row_sel;
            end
            default:
            begin
                if (r.begins_run)
                begin
                    addr = row_bases[cur_row * 8 +: 8] + cur_col;
                    queue_byte(1'b0, addr, {8'd0, settle}, 12'd0);
                end
                queue_byte(1'b1, r.char_code, {8'd0, settle}, 12'd0);
                cur_col = cur_col + 8'd1;
            end
        endcase
        if (nib_expect.size() > start_size)
        begin
            tail = nib_expect.pop_back();
            tail.last = 1'b1;
            nib_expect.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_done))
        begin
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= req_queue.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // nibble receiver, with an optional long hold
    always @(negedge clk)
    begin
        if (hold_on && hold_count < HOLD_CYCLES)
        begin
            nib_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            nib_stall <= ($urandom_range(99) < stall_pct);
            if (!hold_on)
                hold_count <= 0;
        end
    end

    always @(posedge clk)
    begin : beat_monitor
        nib_t want;
        req_done <= req_valid && !req_stall;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_nibbles(req);
                req_count++;
            end
            if (nib_valid && !nib_stall)
            begin
                nib_count++;
                if (nib_expect.size() == 0)
                begin
                    $error("nibble beat with nothing expected: %p", nib);
                    errors++;
                end
                else
                begin
                    want = nib_expect.pop_front();
                    check_field("reg_select", 16'(want.reg_select), 16'(nib.reg_select));
                    check_field("nibble", 16'(want.nibble), 16'(nib.nibble));
                    check_field("pause_before_us", want.pause_before_us, nib.pause_before_us);
                    check_field("pause_after_us", 16'(want.pause_after_us),
                                16'(nib.pause_after_us));
                    check_field("last", 16'(want.last), 16'(nib.last));
                end
            end
            if ((req_valid && !req_stall) || (nib_valid && !nib_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d nibbles outstanding",
                         quiet_cycles, nib_expect.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_request(cmd_t cmd, logic [5:0] col, logic [1:0] row,
                                 logic [7:0] ch, logic run);
        req_t r;
        r.command = cmd;
        r.column = col;
        r.row_sel = row;
        r.char_code = ch;
        r.begins_run = run;
        req_queue.push_back(r);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SETTLE:    settle = value[7:0];
            CFG_LONG_WAIT: long_wait = value[11:0];
            CFG_POWER_UP:  power_up = value[15:0];
            default:       row_bases = value;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_timing(logic [7:0] s, logic [11:0] lw, logic [15:0] pu, logic [31:0] rb);
        write_reg(CFG_SETTLE, {24'd0, s});
        write_reg(CFG_LONG_WAIT, {20'd0, lw});
        write_reg(CFG_POWER_UP, {16'd0, pu});
        write_reg(CFG_ROW_BASES, rb);
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || req_valid || nib_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // mostly cursor-then-run sequences, the rest loose requests
    task automatic add_random_traffic(int count);
        int made;
        int pick;
        int run_len;
        made = 0;
        queue_request(CMD_INIT, 6'($urandom_range(63)), 2'($urandom_range(3)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                queue_request(CMD_SET_CURSOR, 6'($urandom_range(63)), 2'($urandom_range(3)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
                run_len = $urandom_range(1, 8);
                for (int i = 0; i < run_len; i++)
                    queue_request(CMD_WRITE, 6'($urandom_range(63)), 2'($urandom_range(3)),
                                  8'($urandom_range(255)), i == 0);
                made += run_len + 1;
            end
            else
            begin
                if (pick < 80)
                    queue_request(CMD_WRITE, 6'($urandom_range(63)), 2'($urandom_range(3)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)));
                else if (pick < 88)
                    queue_request(CMD_SET_CURSOR, 6'($urandom_range(63)),
                                  2'($urandom_range(3)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
                else if (pick < 96)
                    queue_request(CMD_CLEAR, 6'($urandom_range(63)), 2'($urandom_range(3)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                    queue_request(CMD_INIT, 6'($urandom_range(63)), 2'($urandom_range(3)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    task automatic run_phase(int send_pct, int rcv_pct, int count);
        send_idle_pct = send_pct;
        stall_pct = rcv_pct;
        add_random_traffic(count);
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset timing, no idling
        queue_request(CMD_INIT, 6'd0, 2'd0, 8'd0, 1'b0);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h41, 1'b1);
        queue_request(CMD_WRITE, 6'h3F, 2'd3, 8'h00, 1'b0);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'hFF, 1'b0);
        queue_request(CMD_SET_CURSOR, 6'd39, 2'd1, 8'h55, 1'b1);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'hAA, 1'b1);
        queue_request(CMD_SET_CURSOR, 6'h3F, 2'd3, 8'hFF, 1'b0);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h55, 1'b1);
        queue_request(CMD_SET_CURSOR, 6'd20, 2'd2, 8'h00, 1'b0);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h7E, 1'b1);
        queue_request(CMD_CLEAR, 6'h3F, 2'd3, 8'hFF, 1'b1);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h30, 1'b1);
        queue_request(CMD_SET_CURSOR, 6'd5, 2'd3, 8'd0, 1'b0);
        queue_request(CMD_INIT, 6'h2A, 2'd2, 8'hC3, 1'b1);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h31, 1'b1);
        // cursor at the top of its column range
        queue_request(CMD_SET_CURSOR, 6'h3F, 2'd1, 8'd0, 1'b0);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h20, 1'b1);
        queue_request(CMD_WRITE, 6'd0, 2'd0, 8'h21, 1'b1);
        wait_idle();

        set_timing(8'd255, 12'd4095, 16'd65535, 32'hFFFF_FFFF);
        run_phase(84, 0, 20);

        set_timing(8'd1, 12'd0, 16'd0, 32'h0000_0000);
        run_phase(0, 84, 20);

        set_timing(8'($urandom_range(1, 255)), 12'($urandom_range(4095)),
                   16'($urandom_range(65535)), $urandom());
        run_phase(13, 13, 20);

        // long receiver hold while requests keep coming
        set_timing(RST_SETTLE_US, RST_LONG_WAIT_US, RST_POWER_UP_US, RST_ROW_BASES);
        hold_on = 1'b1;
        run_phase(0, 13, 20);
        hold_on = 1'b0;

        set_timing(8'($urandom_range(1, 255)), 12'($urandom_range(4095)),
                   16'($urandom_range(65535)), $urandom());
        run_phase(0, 0, 20);

        $display("checked %0d requests and %0d nibble beats across six timing settings,",
                 req_count, nib_count);
        $display("with sender gaps, receiver stalls and a %0d-cycle receiver hold",
                 HOLD_CYCLES);
        if (errors == 0 && nib_expect.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/lcdn_pkg.sv
rtl/lcdn_front.sv
rtl/lcdn_queue.sv
rtl/lcdn_back.sv
rtl/char_lcd_nibble_interface.sv
tb/testbench.sv
